@@ sv/battery_power_path_sequencer_assert.svh @@
// ---------------------------------------------------------------------------
// battery power path sequencer assertion macros
// shared property forms for the sequencer checks
// ---------------------------------------------------------------------------
`ifndef BATTERY_POWER_PATH_SEQUENCER_ASSERT_SVH
`define BATTERY_POWER_PATH_SEQUENCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BPPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BPPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bpps_pkg.sv @@
// ---------------------------------------------------------------------------
// bpps_pkg
// types and constants of the battery power path sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpps_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [7:0] POLL_PERIOD_RST  = 8'd10;
  localparam logic [7:0] LONG_PRESS_RST   = 8'd100;
  localparam logic [9:0] OFF_SETTLE_RST   = 10'd100;
  localparam logic [9:0] DIR_SETTLE_RST   = 10'd50;
  localparam logic [7:0] USB_DEBOUNCE_RST = 8'd5;

  localparam logic [8:0] HELD_POLLS_MAX = 9'h1FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_PERIOD   = 3'd0,
    CFG_LONG_PRESS    = 3'd1,
    CFG_OFF_SETTLE    = 3'd2,
    CFG_DIR_SETTLE    = 3'd3,
    CFG_USB_DEBOUNCE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_PLUG_OFF   = 3'd1,
    PH_PLUG_DIR   = 3'd2,
    PH_UNPLUG_OFF = 3'd3,
    PH_UNPLUG_DIR = 3'd4,
    PH_PRESS_DIR  = 3'd5
  } phase_e;

  typedef struct packed {
    logic key_level;
    logic usb_level;
  } in_word_t;

  typedef struct packed {
    logic dcdc_enable_n;
    logic dcdc_direction;
    logic dcdc_aux_enable;
    logic converter_on;
    logic sleep_request;
    logic sequence_busy;
  } out_word_t;

  typedef struct packed {
    logic [7:0] poll_period;
    logic [7:0] long_press_polls;
    logic [9:0] off_settle_ticks;
    logic [9:0] dir_settle_ticks;
    logic [7:0] usb_debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic       plugged;
    logic       plug_changed;
    logic       started;
    logic       last_usb_seen;
    logic [7:0] debounce_left;
    logic       button_held;
    logic [8:0] held_polls;
    logic [7:0] poll_left;
    phase_e     seq_phase;
    logic [9:0] wait_left;
    logic       enable_n;
    logic       direction;
    logic       second_enable;
  } state_t;

endpackage

@@ sv/battery_power_path_sequencer.sv @@
// ---------------------------------------------------------------------------
// battery_power_path_sequencer
// tick-driven power path control for a bidirectional dc-dc converter
// ---------------------------------------------------------------------------
// One input word is one millisecond tick with the button and usb-detect
// levels; every accepted word yields exactly one output word with the
// converter controls after that tick. The block takes one word per clock
// while the output is not stalled: words land in an input register, and the
// whole tick update (usb debounce, poll timer, switching sequence, long
// press) is one pass of next-state logic that writes the state and the
// output register together. With the output stalled the input register
// holds one more word before in_ready_o drops. Configuration writes are
// taken every cycle and should only be issued while no word is in flight.
`timescale 1ns / 1ps

module battery_power_path_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bpps_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bpps_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import bpps_pkg::*;

  `include "battery_power_path_sequencer_assert.svh"

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  logic      in_vld_q;
  in_word_t  in_word_q;
  logic      out_vld_q;
  out_word_t out_word_q, out_word_d;
  logic      adv;

  function automatic state_t button_part(state_t s, logic key, cfg_t c);
    state_t r;
    r = s;
    if (key) begin
      if (!r.button_held) begin
        r.button_held = 1'b1;
        r.held_polls  = '0;
      end else begin
        if (r.held_polls != HELD_POLLS_MAX) begin
          r.held_polls = r.held_polls + 9'd1;
        end
        if (r.held_polls > {1'b0, c.long_press_polls}) begin
          if (!r.enable_n) begin
            if (!r.plugged) begin
              r.enable_n      = 1'b1;
              r.second_enable = 1'b0;
            end
          end else if (!r.plugged) begin
            r.direction = 1'b1;
            r.seq_phase = PH_PRESS_DIR;
            r.wait_left = c.dir_settle_ticks;
          end
          r.held_polls = '0;
        end
      end
    end else begin
      r.button_held = 1'b0;
      r.held_polls  = '0;
    end
    r.poll_left = (c.poll_period == '0) ? '0 : c.poll_period - 8'd1;
    return r;
  endfunction

  function automatic state_t end_wait(state_t s, logic key, cfg_t c);
    state_t r;
    r = s;
    case (r.seq_phase)
      PH_PLUG_OFF: begin
        r.direction = 1'b0;
        r.seq_phase = PH_PLUG_DIR;
        r.wait_left = c.dir_settle_ticks;
      end
      PH_PLUG_DIR, PH_UNPLUG_DIR: begin
        r.enable_n      = 1'b0;
        r.second_enable = 1'b1;
        r.seq_phase     = PH_IDLE;
        r               = button_part(r, key, c);
      end
      PH_UNPLUG_OFF: begin
        r.direction = 1'b1;
        r.seq_phase = PH_UNPLUG_DIR;
        r.wait_left = c.dir_settle_ticks;
      end
      PH_PRESS_DIR: begin
        r.enable_n  = 1'b0;
        r.seq_phase = PH_IDLE;
      end
      default: begin
        r.seq_phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // zero waits chain through at most three phase steps
  function automatic state_t settle(state_t s, logic key, cfg_t c);
    state_t r;
    r = s;
    for (int i = 0; i < 3; i++) begin
      if (r.seq_phase != PH_IDLE && r.wait_left == '0) begin
        r = end_wait(r, key, c);
      end
    end
    return r;
  endfunction

  function automatic state_t poll(state_t s, logic key, cfg_t c);
    state_t r;
    logic   started_seq;
    r           = s;
    started_seq = 1'b0;
    if (r.plug_changed) begin
      r.plug_changed = 1'b0;
      if (r.plugged) begin
        if (!r.enable_n) begin
          r.enable_n  = 1'b1;
          r.seq_phase = PH_PLUG_OFF;
          r.wait_left = c.off_settle_ticks;
        end else begin
          r.direction = 1'b0;
          r.seq_phase = PH_PLUG_DIR;
          r.wait_left = c.dir_settle_ticks;
        end
        started_seq = 1'b1;
      end else if (!r.enable_n) begin
        r.enable_n  = 1'b1;
        r.seq_phase = PH_UNPLUG_OFF;
        r.wait_left = c.off_settle_ticks;
        started_seq = 1'b1;
      end else begin
        r.second_enable = 1'b1;
      end
    end
    if (!started_seq) begin
      r = button_part(r, key, c);
    end
    r = settle(r, key, c);
    return r;
  endfunction

  assign adv         = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    state_t s;
    logic   usb;
    s   = state_q;
    usb = in_word_q.usb_level;

    // usb debounce
    if (!s.started) begin
      s.started       = 1'b1;
      s.plugged       = ~usb;
      s.last_usb_seen = usb;
    end else if (s.debounce_left != '0) begin
      s.debounce_left = s.debounce_left - 8'd1;
      if (s.debounce_left == '0) begin
        s.plugged       = ~usb;
        s.last_usb_seen = usb;
        s.plug_changed  = 1'b1;
      end
    end else if (usb != s.last_usb_seen) begin
      if (cfg_q.usb_debounce_ticks == '0) begin
        s.plugged       = ~usb;
        s.last_usb_seen = usb;
        s.plug_changed  = 1'b1;
      end else begin
        s.debounce_left = cfg_q.usb_debounce_ticks;
      end
    end

    // sequence or poll timer
    if (s.seq_phase != PH_IDLE) begin
      if (s.wait_left != '0) begin
        s.wait_left = s.wait_left - 10'd1;
      end
      s = settle(s, in_word_q.key_level, cfg_q);
    end else if (s.poll_left != '0) begin
      s.poll_left = s.poll_left - 8'd1;
    end else begin
      s = poll(s, in_word_q.key_level, cfg_q);
    end

    state_d                     = s;
    out_word_d.dcdc_enable_n    = s.enable_n;
    out_word_d.dcdc_direction   = s.direction;
    out_word_d.dcdc_aux_enable  = s.second_enable;
    out_word_d.converter_on     = ~s.enable_n;
    out_word_d.sleep_request    = (s.seq_phase == PH_IDLE) && !s.button_held &&
                                  !s.plugged && s.enable_n;
    out_word_d.sequence_busy    = (s.seq_phase != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_period        <= POLL_PERIOD_RST;
      cfg_q.long_press_polls   <= LONG_PRESS_RST;
      cfg_q.off_settle_ticks   <= OFF_SETTLE_RST;
      cfg_q.dir_settle_ticks   <= DIR_SETTLE_RST;
      cfg_q.usb_debounce_ticks <= USB_DEBOUNCE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POLL_PERIOD:  cfg_q.poll_period        <= cfg_data_i[7:0];
        CFG_LONG_PRESS:   cfg_q.long_press_polls   <= cfg_data_i[7:0];
        CFG_OFF_SETTLE:   cfg_q.off_settle_ticks   <= cfg_data_i[9:0];
        CFG_DIR_SETTLE:   cfg_q.dir_settle_ticks   <= cfg_data_i[9:0];
        CFG_USB_DEBOUNCE: cfg_q.usb_debounce_ticks <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{plugged: 1'b0, plug_changed: 1'b0, started: 1'b0,
                     last_usb_seen: 1'b1, debounce_left: '0, button_held: 1'b0,
                     held_polls: '0, poll_left: '0, seq_phase: PH_IDLE,
                     wait_left: '0, enable_n: 1'b1, direction: 1'b1,
                     second_enable: 1'b0};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
    if (adv) begin
      out_word_q <= out_word_d;
    end
  end

  `BPPS_ASSERT_NEXT(a_phase_holds, clk_i, rst_ni,
    !adv, state_q.seq_phase == $past(state_q.seq_phase), "phase moved without a word")
  `BPPS_ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni,
    adv, out_vld_q, "advanced word lost from output register")
  `BPPS_ASSERT_NOW(a_in_stage_guard, clk_i, rst_ni,
    in_vld_q && !adv, !in_ready_o, "held input word could be overwritten")
  `BPPS_ASSERT_NOW(a_off_settle_off, clk_i, rst_ni,
    state_q.seq_phase == PH_PLUG_OFF || state_q.seq_phase == PH_UNPLUG_OFF,
    state_q.enable_n, "converter enabled during off settle")
  `BPPS_ASSERT_NEXT(a_poll_countdown, clk_i, rst_ni,
    adv && state_q.seq_phase == PH_IDLE && state_q.poll_left != '0,
    state_q.poll_left == $past(state_q.poll_left) - 8'd1, "poll timer skipped")

endmodule
